// ===== design/d4ia_pkg.sv =====
// ----------------------------------------------------------------------------
// d4ia_pkg: shared definitions for the D4 inverse accumulate averager
// Sizes of the image store, field widths, register indexes and the work
// descriptor that travels from the front end to the accumulate back end.
// ----------------------------------------------------------------------------
package d4ia_pkg;

  // Image and stream geometry
  localparam int MAX_DIM      = 512;
  localparam int MAX_CHANNELS = 4;
  localparam int NUM_PASSES   = 8;

  localparam int DIM_W     = $clog2(MAX_DIM);
  localparam int CFG_DIM_W = DIM_W + 1;
  localparam int CH_W      = $clog2(MAX_CHANNELS);
  localparam int CFG_CH_W  = CH_W + 1;
  localparam int PASS_W    = $clog2(NUM_PASSES);
  localparam int SAMPLE_W  = 8;
  localparam int SUM_W     = SAMPLE_W + PASS_W;

  // Store addressing: row, column, channel
  localparam int ADDR_W      = 2 * DIM_W + CH_W;
  localparam int STORE_DEPTH = 1 << ADDR_W;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = CFG_DIM_W;

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 2'd2;

  // Symmetry operation bits of the pass index
  localparam int OP_MIRROR_X  = 0;
  localparam int OP_MIRROR_Y  = 1;
  localparam int OP_TRANSPOSE = 2;

  localparam logic [PASS_W-1:0] FIRST_PASS = '0;
  localparam logic [PASS_W-1:0] FINAL_PASS = PASS_W'(NUM_PASSES - 1);

  // Queue between front end and back end
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = QPTR_W + 1;

  // One classified sample, ready to be accumulated
  typedef struct packed {
    logic [DIM_W-1:0]    x;
    logic [DIM_W-1:0]    y;
    logic [CH_W-1:0]     k;
    logic [SAMPLE_W-1:0] sample;
    logic                first_pass;
    logic                final_pass;
    logic                last;
  } work_t;

  // Queue fill status seen by both ends
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// ===== design/d4ia_if.sv =====
// ----------------------------------------------------------------------------
// d4ia stream interfaces
// Valid/ready channels for incoming samples and outgoing averaged pixels.
// ----------------------------------------------------------------------------
interface d4ia_in_if;
  import d4ia_pkg::*;

  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface d4ia_out_if;
  import d4ia_pkg::*;

  logic                valid;
  logic                ready;
  logic [DIM_W-1:0]    dest_x;
  logic [DIM_W-1:0]    dest_y;
  logic [CH_W-1:0]     channel;
  logic [SAMPLE_W-1:0] average;
  logic                last;

  modport source (output valid, output dest_x, output dest_y, output channel,
                  output average, output last, input ready);
  modport sink   (input valid, input dest_x, input dest_y, input channel,
                  input average, input last, output ready);
endinterface

// ===== design/d4ia_ram.sv =====
// ----------------------------------------------------------------------------
// d4ia_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module d4ia_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port, holds its data while not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/d4ia_front.sv =====
// ----------------------------------------------------------------------------
// d4ia_front: sample intake and coordinate mapping
// Holds the configuration and the pass/raster counters, inverts the D4
// symmetry of the current pass and pushes one work descriptor per beat.
// ----------------------------------------------------------------------------
module d4ia_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [d4ia_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [d4ia_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  d4ia_in_if.sink                       in_s,
  input  d4ia_pkg::q_stat_t             q_stat_i,
  output logic                          push_o,
  output d4ia_pkg::work_t               push_data_o
);
  import d4ia_pkg::*;

  // Clamp a dimension register to 1..MAX_DIM
  function automatic logic [CFG_DIM_W-1:0] clamp_dim(input logic [CFG_DIM_W-1:0] v);
    logic [CFG_DIM_W-1:0] r;
    r = v;
    if (v == '0) r = CFG_DIM_W'(1);
    else if (v > CFG_DIM_W'(MAX_DIM)) r = CFG_DIM_W'(MAX_DIM);
    return r;
  endfunction

  // Clamp a channel count to 1..MAX_CHANNELS
  function automatic logic [CFG_CH_W-1:0] clamp_ch(input logic [CFG_CH_W-1:0] v);
    logic [CFG_CH_W-1:0] r;
    r = v;
    if (v == '0) r = CFG_CH_W'(1);
    else if (v > CFG_CH_W'(MAX_CHANNELS)) r = CFG_CH_W'(MAX_CHANNELS);
    return r;
  endfunction

  logic [CFG_DIM_W-1:0] width_q, height_q;
  logic [CFG_CH_W-1:0]  chans_q;
  logic [PASS_W-1:0]    pass_q, pass_d;
  logic [DIM_W-1:0]     col_q, col_d, row_q, row_d;
  logic [CH_W-1:0]      chan_q, chan_d;

  logic                 cfg_hit;
  logic                 accept;
  logic                 tr;
  logic [CFG_DIM_W-1:0] tw, th;
  logic [DIM_W-1:0]     w_m1, h_m1;
  logic [DIM_W-1:0]     mx, my, x, y;
  logic [CH_W-1:0]      k;
  logic                 last_chan, last_col, last_row;

  assign cfg_hit = cfg_we_i && ((cfg_idx_i == CFG_IMAGE_WIDTH) ||
                                (cfg_idx_i == CFG_IMAGE_HEIGHT) ||
                                (cfg_idx_i == CFG_CHANNEL_COUNT));

  // Configuration registers, stored already clamped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= CFG_DIM_W'(MAX_DIM);
      height_q <= CFG_DIM_W'(MAX_DIM);
      chans_q  <= CFG_CH_W'(3);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_IMAGE_WIDTH:   width_q  <= clamp_dim(cfg_wdata_i);
        CFG_IMAGE_HEIGHT:  height_q <= clamp_dim(cfg_wdata_i);
        CFG_CHANNEL_COUNT: chans_q  <= clamp_ch(cfg_wdata_i[CFG_CH_W-1:0]);
        default: ;
      endcase
    end
  end

  // Handshake: a beat goes straight into the queue
  assign in_s.ready = !q_stat_i.full;
  assign accept     = in_s.valid && in_s.ready;

  // Inverse D4 mapping of the current raster position
  always_comb begin
    tr   = pass_q[OP_TRANSPOSE];
    tw   = tr ? height_q : width_q;
    th   = tr ? width_q : height_q;
    w_m1 = DIM_W'(width_q - CFG_DIM_W'(1));
    h_m1 = DIM_W'(height_q - CFG_DIM_W'(1));
    mx   = tr ? row_q : col_q;
    my   = tr ? col_q : row_q;
    if ({1'b0, mx} >= width_q) mx = w_m1;
    if ({1'b0, my} >= height_q) my = h_m1;
    x = pass_q[OP_MIRROR_X] ? DIM_W'(w_m1 - mx) : mx;
    y = pass_q[OP_MIRROR_Y] ? DIM_W'(h_m1 - my) : my;
    k = chan_q;
    if ({1'b0, chan_q} >= chans_q) k = CH_W'(chans_q - CFG_CH_W'(1));

    last_chan = ({1'b0, chan_q} + CFG_CH_W'(1)) >= chans_q;
    last_col  = ({1'b0, col_q} + CFG_DIM_W'(1)) >= tw;
    last_row  = ({1'b0, row_q} + CFG_DIM_W'(1)) >= th;
  end

  // Raster and pass counters
  always_comb begin
    pass_d = pass_q;
    col_d  = col_q;
    row_d  = row_q;
    chan_d = chan_q;
    if (cfg_hit) begin
      pass_d = '0;
      col_d  = '0;
      row_d  = '0;
      chan_d = '0;
    end else if (accept) begin
      if (last_chan) begin
        chan_d = '0;
        if (last_col) begin
          col_d = '0;
          if (last_row) begin
            row_d  = '0;
            pass_d = pass_q + PASS_W'(1);
          end else begin
            row_d = row_q + DIM_W'(1);
          end
        end else begin
          col_d = col_q + DIM_W'(1);
        end
      end else begin
        chan_d = chan_q + CH_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pass_q <= '0;
      col_q  <= '0;
      row_q  <= '0;
      chan_q <= '0;
    end else begin
      pass_q <= pass_d;
      col_q  <= col_d;
      row_q  <= row_d;
      chan_q <= chan_d;
    end
  end

  // Work descriptor for the back end
  assign push_o                 = accept;
  assign push_data_o.x          = x;
  assign push_data_o.y          = y;
  assign push_data_o.k          = k;
  assign push_data_o.sample     = in_s.sample;
  assign push_data_o.first_pass = (pass_q == FIRST_PASS);
  assign push_data_o.final_pass = (pass_q == FINAL_PASS);
  assign push_data_o.last       = last_chan && last_col && last_row;

endmodule

// ===== design/d4ia_queue.sv =====
// ----------------------------------------------------------------------------
// d4ia_queue: short work queue
// A small register FIFO that decouples sample intake from the accumulate
// pipeline, so that either side may stall on its own.
// ----------------------------------------------------------------------------
module d4ia_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  d4ia_pkg::work_t    push_data_i,
  input  logic               pop_i,
  output d4ia_pkg::work_t    head_o,
  output d4ia_pkg::q_stat_t  stat_o
);
  import d4ia_pkg::*;

  work_t             slot_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] count_q;
  logic              do_push, do_pop;

  assign stat_o.full  = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign stat_o.empty = (count_q == '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign head_o       = slot_q[rd_ptr_q];

  // Storage slots
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      if (do_pop) rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      case ({do_push, do_pop})
        2'b10:   count_q <= count_q + QCNT_W'(1);
        2'b01:   count_q <= count_q - QCNT_W'(1);
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

// ===== design/d4ia_back.sv =====
// ----------------------------------------------------------------------------
// d4ia_back: accumulate pipeline and result register
// Adds each sample to its destination's running sum in the store (first
// pass starts anew) and, on the final pass, gives the rounded average.
// ----------------------------------------------------------------------------
module d4ia_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  d4ia_pkg::work_t    head_i,
  input  d4ia_pkg::q_stat_t  q_stat_i,
  output logic               pop_o,
  d4ia_out_if.source         out_s
);
  import d4ia_pkg::*;

  work_t               s2_q;
  logic                s2_valid_q;
  logic                s2_fire;
  logic [ADDR_W-1:0]   head_addr, s2_addr;

  logic [SUM_W-1:0]    rdata, old_sum, new_sum;
  logic [SUM_W:0]      rounded;

  logic                lw_valid_q;
  logic [ADDR_W-1:0]   lw_addr_q;
  logic [SUM_W-1:0]    lw_sum_q;

  logic                out_valid_q;
  logic [DIM_W-1:0]    out_x_q, out_y_q;
  logic [CH_W-1:0]     out_k_q;
  logic [SAMPLE_W-1:0] out_avg_q;
  logic                out_last_q;

  assign head_addr = {head_i.y, head_i.x, head_i.k};
  assign s2_addr   = {s2_q.y, s2_q.x, s2_q.k};

  // Stage 2 retires unless it must hand a result to a full output register
  assign s2_fire = s2_valid_q && (!s2_q.final_pass || !out_valid_q || out_s.ready);
  assign pop_o   = !q_stat_i.empty && (!s2_valid_q || s2_fire);

  d4ia_ram #(
    .WIDTH (SUM_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (s2_fire),
    .waddr_i (s2_addr),
    .wdata_i (new_sum),
    .re_i    (pop_o),
    .raddr_i (head_addr),
    .rdata_o (rdata)
  );

  // Read stage: issue the store read and capture the descriptor
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (pop_o) begin
      s2_valid_q <= 1'b1;
    end else if (s2_fire) begin
      s2_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      s2_q <= head_i;
    end
  end

  // Accumulate: the previous write is forwarded when it hit the same entry,
  // since its read went out on the very edge that wrote it
  always_comb begin
    old_sum = (lw_valid_q && (lw_addr_q == s2_addr)) ? lw_sum_q : rdata;
    if (s2_q.first_pass) begin
      new_sum = SUM_W'(s2_q.sample);
    end else begin
      new_sum = old_sum + SUM_W'(s2_q.sample);
    end
    rounded = {1'b0, new_sum} + (SUM_W + 1)'(NUM_PASSES / 2);
  end

  // Last write, kept for forwarding
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lw_valid_q <= 1'b0;
    end else if (s2_fire) begin
      lw_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_fire) begin
      lw_addr_q <= s2_addr;
      lw_sum_q  <= new_sum;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s2_fire && s2_q.final_pass) begin
      out_valid_q <= 1'b1;
    end else if (out_s.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_fire && s2_q.final_pass) begin
      out_x_q    <= s2_q.x;
      out_y_q    <= s2_q.y;
      out_k_q    <= s2_q.k;
      out_avg_q  <= rounded[PASS_W +: SAMPLE_W];
      out_last_q <= s2_q.last;
    end
  end

  assign out_s.valid   = out_valid_q;
  assign out_s.dest_x  = out_x_q;
  assign out_s.dest_y  = out_y_q;
  assign out_s.channel = out_k_q;
  assign out_s.average = out_avg_q;
  assign out_s.last    = out_last_q;

`ifndef SYNTHESIS
  // A blocked stage 2 keeps its descriptor
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_valid_q && !s2_fire |=> s2_valid_q && $stable(s2_q))
    else $error("stage 2 descriptor changed while stalled");

  // A retiring final-pass beat lands in the output register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_fire && s2_q.final_pass |=> out_valid_q)
    else $error("final-pass result lost");

  // The forwarding register tracks the last store write
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_fire |=> lw_valid_q && (lw_addr_q == $past(s2_addr)))
    else $error("forwarding register out of step with store writes");
`endif

endmodule

// ===== design/d4_inverse_accumulate_average.sv =====
// ----------------------------------------------------------------------------
// d4_inverse_accumulate_average: eight-pass D4 averaging of an image
// Takes eight symmetry-transformed passes of one image and emits, during the
// last pass, the rounded mean of the eight samples for each output sample.
// ----------------------------------------------------------------------------
// Usage
//   in_s carries one 8-bit channel sample per beat, in raster order of the
//   current transformed pass with channels interleaved. out_s carries one
//   beat per sample of the final pass: destination column, row, channel,
//   rounded average and a last flag on the very last sample of the frame.
//   The block takes one beat per cycle while its queue is not full. A beat
//   is queued at its accepting edge, then popped into the read stage as it
//   reads the sum store, and then written into the output register, where
//   its result becomes valid. The single read and single write port of the
//   sum store set the rate at one beat a cycle.
//   When out_s is stalled, final-pass beats back up into a four-entry queue
//   and then in_s.ready drops; earlier passes keep flowing while no result
//   waits for the output.
//   Reset sets 512 x 512 pixels with 3 channels and starts at pass 0. The sum
//   store is not cleared; pass 0 overwrites every entry it uses. Any register
//   write restarts the frame at pass 0 and must be made while the block is
//   empty.
// ----------------------------------------------------------------------------
module d4_inverse_accumulate_average (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [d4ia_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [d4ia_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  d4ia_in_if.sink                         in_s,
  d4ia_out_if.source                      out_s
);
  import d4ia_pkg::*;

  logic    push, pop;
  work_t   push_data, head;
  q_stat_t q_stat;

  // Intake, configuration and coordinate mapping
  d4ia_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_s        (in_s),
    .q_stat_i    (q_stat),
    .push_o      (push),
    .push_data_o (push_data)
  );

  // Decoupling queue
  d4ia_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .head_o      (head),
    .stat_o      (q_stat)
  );

  // Accumulate pipeline and result register
  d4ia_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .head_i   (head),
    .q_stat_i (q_stat),
    .pop_o    (pop),
    .out_s    (out_s)
  );

endmodule
